// ===== design/hbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver package
// Shared types, result codes and the CRC-16/X.25 byte update.
// ----------------------------------------------------------------------------
package hbrd_pkg;

  localparam int unsigned LEN_W            = 13;
  localparam int unsigned HBRD_QUEUE_DEPTH = 6;

  localparam logic [7:0]  FLAG_PATTERN  = 8'h7E;
  localparam logic [6:0]  ABORT_PATTERN = 7'h7F;
  localparam logic [5:0]  STUFF_PATTERN = 6'h3E;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [15:0] CRC_PRESET    = 16'hFFFF;

  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 13'd6;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 13'd512;

  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_GOOD     = 3'd1;
  localparam logic [2:0] KIND_SHORT    = 3'd2;
  localparam logic [2:0] KIND_CRCFAIL  = 3'd3;
  localparam logic [2:0] KIND_ABORT    = 3'd4;
  localparam logic [2:0] KIND_OVERSIZE = 3'd5;

  localparam logic REG_MIN_LEN = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       data_byte;
    logic [LEN_W-1:0] body_len;
  } hbrd_result_t;

  // Up to two results per line bit; slot 0 is always filled first.
  typedef struct packed {
    logic         valid0;
    logic         valid1;
    hbrd_result_t res0;
    hbrd_result_t res1;
  } hbrd_push_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== design/hbrd_if.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver channel interfaces
// Line bit input channel and result output channel, valid/ready.
// ----------------------------------------------------------------------------
interface hbrd_in_if;
  logic valid;
  logic ready;
  logic line_bit;

  modport source (output valid, output line_bit, input ready);
  modport sink   (input valid, input line_bit, output ready);
endinterface

interface hbrd_out_if;
  import hbrd_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       data_byte;
  logic [LEN_W-1:0] body_len;

  modport source  (output valid, output kind, output data_byte, output body_len,
                   input ready);
  modport sink    (input valid, input kind, input data_byte, input body_len,
                   output ready);
endinterface

// ===== design/hbrd_core.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver core
// Registered line bit, flag/abort/stuff detection, byte assembly, FCS
// holdback, CRC-16/X.25 and status generation in one pass per bit.
// ----------------------------------------------------------------------------
module hbrd_core
  import hbrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             bit_accept,
  input  logic             bit_in,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_wdata,
  output logic             pend,
  output hbrd_push_t       push
);

  logic             pend_r, bit_r;
  logic [7:0]       win_r, win_nxt;
  logic [7:0]       asm_r, asm_nxt;
  logic [2:0]       bitcnt_r, bitcnt_nxt;
  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] bytecnt_r, bytecnt_nxt, cnt_inc;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       hold0_r, hold0_nxt, hold1_r, hold1_nxt;
  logic [LEN_W-1:0] min_len_r, max_len_r;
  logic             fcs_ok;

  assign pend = pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= 1'b0;
      win_r      <= '0;
      asm_r      <= '0;
      bitcnt_r   <= '0;
      in_frame_r <= 1'b0;
      bytecnt_r  <= '0;
      crc_r      <= CRC_PRESET;
      hold0_r    <= '0;
      hold1_r    <= '0;
      min_len_r  <= MIN_LEN_RESET;
      max_len_r  <= MAX_LEN_RESET;
    end else begin
      pend_r     <= bit_accept;
      win_r      <= win_nxt;
      asm_r      <= asm_nxt;
      bitcnt_r   <= bitcnt_nxt;
      in_frame_r <= in_frame_nxt;
      bytecnt_r  <= bytecnt_nxt;
      crc_r      <= crc_nxt;
      hold0_r    <= hold0_nxt;
      hold1_r    <= hold1_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_LEN: min_len_r <= cfg_wdata;
          REG_MAX_LEN: max_len_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bit_accept) begin
      bit_r <= bit_in;
    end
  end

  assign cnt_inc = bytecnt_r + LEN_W'(1);
  assign fcs_ok  = ({hold1_r, hold0_r} == ~crc_r);

  always_comb begin
    win_nxt      = win_r;
    asm_nxt      = asm_r;
    bitcnt_nxt   = bitcnt_r;
    in_frame_nxt = in_frame_r;
    bytecnt_nxt  = bytecnt_r;
    crc_nxt      = crc_r;
    hold0_nxt    = hold0_r;
    hold1_nxt    = hold1_r;
    push         = '0;

    if (pend_r) begin
      win_nxt = {win_r[6:0], bit_r};
      if (win_nxt == FLAG_PATTERN) begin
        if (!in_frame_r) begin
          in_frame_nxt = 1'b1;
          bitcnt_nxt   = '0;
          bytecnt_nxt  = '0;
          crc_nxt      = CRC_PRESET;
        end else begin
          in_frame_nxt = 1'b0;
          push.valid0  = 1'b1;
          if (bytecnt_r < LEN_W'(2) || bytecnt_r < min_len_r) begin
            push.res0.kind = KIND_SHORT;
          end else if (fcs_ok) begin
            push.res0.kind     = KIND_GOOD;
            push.res0.body_len = bytecnt_r - LEN_W'(2);
          end else begin
            push.res0.kind = KIND_CRCFAIL;
          end
        end
      end else if (in_frame_r) begin
        if (win_nxt[6:0] == ABORT_PATTERN) begin
          in_frame_nxt   = 1'b0;
          push.valid0    = 1'b1;
          push.res0.kind = KIND_ABORT;
        end else if (win_nxt[5:0] != STUFF_PATTERN) begin
          asm_nxt    = {bit_r, asm_r[7:1]};
          bitcnt_nxt = bitcnt_r + 3'd1;
          if (bitcnt_r == 3'd7) begin
            hold0_nxt   = hold1_r;
            hold1_nxt   = asm_nxt;
            bytecnt_nxt = cnt_inc;
            if (bytecnt_r >= LEN_W'(2)) begin
              // oldest held byte is now known to be payload
              crc_nxt             = crc_feed(crc_r, hold0_r);
              push.valid0         = 1'b1;
              push.res0.kind      = KIND_DATA;
              push.res0.data_byte = hold0_r;
            end
            if (cnt_inc >= max_len_r) begin
              in_frame_nxt = 1'b0;
              if (bytecnt_r >= LEN_W'(2)) begin
                push.valid1    = 1'b1;
                push.res1.kind = KIND_OVERSIZE;
              end else begin
                push.valid0    = 1'b1;
                push.res0.kind = KIND_OVERSIZE;
              end
            end
          end
        end
      end
    end
  end

endmodule

// ===== design/hbrd_queue.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver result queue
// Small register queue taking up to two results per cycle, draining one while out_ready is high.
// ----------------------------------------------------------------------------
module hbrd_queue
  import hbrd_pkg::*;
#(
  parameter int unsigned DEPTH = HBRD_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  hbrd_push_t   push,
  input  logic         pend,
  output logic         space_ok,
  output logic         out_valid,
  input  logic         out_ready,
  output hbrd_result_t out_res
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  hbrd_result_t     mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt, wr_ptr1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  logic [1:0]       n_push;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_ptr_r];
  assign n_push    = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign wr_ptr1   = ptr_inc(wr_ptr_r);

  // Room for the transaction in flight plus the one being accepted now.
  assign space_ok  = ({1'b0, count_r} + (pend ? (CNT_W+1)'(2) : '0))
                     <= (CNT_W+1)'(DEPTH - 2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) begin
      wr_ptr_nxt = wr_ptr1;
    end else if (n_push == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr1);
    end
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.valid1) begin
      mem[wr_ptr1] <= push.res1;
    end
  end

endmodule

// ===== design/hdlc_bit_receiver_deframer.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver and deframer
// Flag/abort/stuffing handling, byte assembly and CRC-16/X.25 frame check.
// ----------------------------------------------------------------------------
// One line bit is taken per clock cycle while in_chan.ready is high. A bit is
// registered, processed in the next cycle, and any results it causes enter a
// short result queue. A bit gives at most two results (the last data byte and
// an oversize status); the queue drains one result per cycle while
// out_chan.ready is high, and in_chan.ready drops only when the queue cannot
// hold the results of the bit in flight plus one more bit, which happens only
// when the result side holds off. Payload bytes come out LSB-first-assembled,
// with the two FCS bytes held back; each frame ends with one status result.
module hdlc_bit_receiver_deframer
  import hbrd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = HBRD_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  hbrd_in_if.sink          in_chan,
  hbrd_out_if.source       out_chan,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [LEN_W-1:0] cfg_wdata
);

  hbrd_push_t   push;
  hbrd_result_t out_res;
  logic         pend;
  logic         space_ok;
  logic         bit_accept;

  assign in_chan.ready = space_ok;
  assign bit_accept    = in_chan.valid && space_ok;

  hbrd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .bit_accept (bit_accept),
    .bit_in     (in_chan.line_bit),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pend       (pend),
    .push       (push)
  );

  hbrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pend      (pend),
    .space_ok  (space_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.kind      = out_res.kind;
  assign out_chan.data_byte = out_res.data_byte;
  assign out_chan.body_len  = out_res.body_len;

endmodule

// ===== design/hbrd_checker.sv =====
// ----------------------------------------------------------------------------
// HDLC bit receiver port checker
// Checks result field consistency and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
module hbrd_checker
  import hbrd_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [2:0]       out_kind,
  input logic [7:0]       out_data_byte,
  input logic [LEN_W-1:0] out_body_len
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_OVERSIZE))
    else $error("result kind out of range");

  a_data_only_on_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DATA) |-> (out_data_byte == 8'h00))
    else $error("data byte set on status result");

  a_len_only_on_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_GOOD) |-> (out_body_len == '0))
    else $error("payload length set on non-good result");

  // a stalled transaction stays put until taken
  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_kind) && $stable(out_data_byte) && $stable(out_body_len)))
    else $error("result changed while stalled");

endmodule

bind hdlc_bit_receiver_deframer hbrd_checker u_hbrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_kind      (out_chan.kind),
  .out_data_byte (out_chan.data_byte),
  .out_body_len  (out_chan.body_len)
);

// ===== tb/tb_hdlc_bit_receiver_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC bit receiver testbench
// Feeds line bits (flags, stuffed frames with good or broken FCS, aborts,
// noise) through the valid/ready input, with random idling on both sides and
// one long result stall. A bit-level deframer model, or a typed table row,
// predicts every data byte and frame status; results are checked in order.
// ----------------------------------------------------------------------------
module tb_hdlc_bit_receiver_deframer;
  import hbrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned PHASE_BITS   = 40;
  localparam int unsigned SQUEEZE_AT   = 30;
  localparam int unsigned SQUEEZE_LEN  = 400;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {ROW_BITS, ROW_FRAME, ROW_CFG} row_op_e;
  typedef enum logic [1:0] {FR_GOOD, FR_BAD_FCS, FR_NO_FCS, FR_RANDOM} frame_mode_e;
  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    row_op_e          op;
    logic             reg_sel;   // register for ROW_CFG
    logic [31:0]      pattern;   // line bits (MSB first), fill byte or register value
    logic [5:0]       count;     // number of line bits or payload bytes
    frame_mode_e      fmode;
    logic             typed;     // results below replace the model's for this row
    logic [3:0]       n_data;    // data bytes expected, all equal to the fill byte
    logic [2:0]       status;    // KIND_DATA here means no status result
    logic [LEN_W-1:0] good_len;
  } stim_row_t;

  localparam stim_row_t DIR_TABLE [27] = '{
    '{ROW_BITS,  REG_MIN_LEN, 32'h7E,   6'd8,  FR_GOOD,    1'b1, 4'd0, KIND_DATA,     13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'h7E,   6'd8,  FR_GOOD,    1'b1, 4'd0, KIND_SHORT,    13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'h7F,   6'd7,  FR_GOOD,    1'b1, 4'd0, KIND_DATA,     13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'h7E,   6'd8,  FR_GOOD,    1'b1, 4'd0, KIND_DATA,     13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'h7F,   6'd7,  FR_GOOD,    1'b1, 4'd0, KIND_ABORT,    13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'hFFFF, 6'd16, FR_GOOD,    1'b1, 4'd0, KIND_DATA,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h00,   6'd4,  FR_GOOD,    1'b1, 4'd4, KIND_GOOD,     13'd4},
    '{ROW_FRAME, REG_MIN_LEN, 32'hFF,   6'd4,  FR_GOOD,    1'b1, 4'd4, KIND_GOOD,     13'd4},
    '{ROW_FRAME, REG_MIN_LEN, 32'h7E,   6'd4,  FR_GOOD,    1'b1, 4'd4, KIND_GOOD,     13'd4},
    '{ROW_FRAME, REG_MIN_LEN, 32'hA5,   6'd4,  FR_BAD_FCS, 1'b1, 4'd4, KIND_CRCFAIL,  13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h55,   6'd2,  FR_GOOD,    1'b1, 4'd2, KIND_SHORT,    13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h00,   6'd0,  FR_GOOD,    1'b1, 4'd0, KIND_SHORT,    13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'hC3,   6'd1,  FR_NO_FCS,  1'b1, 4'd0, KIND_SHORT,    13'd0},
    '{ROW_CFG,   REG_MIN_LEN, 32'd0,    6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h00,   6'd0,  FR_GOOD,    1'b1, 4'd0, KIND_GOOD,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h99,   6'd1,  FR_NO_FCS,  1'b1, 4'd0, KIND_SHORT,    13'd0},
    '{ROW_CFG,   REG_MAX_LEN, 32'd3,    6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h3C,   6'd4,  FR_GOOD,    1'b1, 4'd1, KIND_OVERSIZE, 13'd0},
    // closing flag of the cut-off frame opened a new one; this flag closes it
    '{ROW_BITS,  REG_MIN_LEN, 32'h7E,   6'd8,  FR_GOOD,    1'b1, 4'd0, KIND_SHORT,    13'd0},
    '{ROW_CFG,   REG_MAX_LEN, 32'd4096, 6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_CFG,   REG_MIN_LEN, 32'd4096, 6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h81,   6'd4,  FR_GOOD,    1'b1, 4'd4, KIND_SHORT,    13'd0},
    '{ROW_CFG,   REG_MIN_LEN, 32'd6,    6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_CFG,   REG_MAX_LEN, 32'd512,  6'd0,  FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_FRAME, REG_MIN_LEN, 32'h00,   6'd6,  FR_RANDOM,  1'b0, 4'd0, KIND_DATA,     13'd0},
    // two flags sharing one zero
    '{ROW_BITS,  REG_MIN_LEN, 32'h3F7E, 6'd15, FR_GOOD,    1'b0, 4'd0, KIND_DATA,     13'd0},
    '{ROW_BITS,  REG_MIN_LEN, 32'hF0F03C3C, 6'd32, FR_GOOD, 1'b0, 4'd0, KIND_DATA,    13'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_index;
  logic [LEN_W-1:0] cfg_wdata;

  hbrd_in_if  in_chan ();
  hbrd_out_if out_chan ();

  hdlc_bit_receiver_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // deframer model state
  logic [7:0]       rx_win   = 8'h00;
  logic [7:0]       rx_shift = 8'h00;
  logic [2:0]       rx_nbits = 3'd0;
  logic             rx_open  = 1'b0;
  logic [LEN_W-1:0] rx_count = '0;
  logic [15:0]      rx_crc   = CRC_PRESET;
  logic [7:0]       rx_hold [2] = '{8'h00, 8'h00};
  logic [LEN_W-1:0] min_len  = MIN_LEN_RESET;
  logic [LEN_W-1:0] max_len  = MAX_LEN_RESET;

  hbrd_result_t due_results[$];
  logic         line_q[$];
  bit           table_owns_results = 1'b0;
  int unsigned  ones_run = 0;
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  bit           in_calm = 1'b0;
  bit           out_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [15:0] x25_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void queue_expect(input logic [2:0] kind, input logic [7:0] data,
                                       input logic [LEN_W-1:0] len);
    hbrd_result_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.body_len  = len;
    due_results.push_back(r);
  endfunction

  function automatic void model_emit(input logic [2:0] kind, input logic [7:0] data,
                                     input logic [LEN_W-1:0] len);
    if (!table_owns_results) queue_expect(kind, data, len);
  endfunction

  // one accepted line bit through the deframer model
  function automatic void deframe_bit(input logic b);
    logic [15:0] fcs;
    rx_win = {rx_win[6:0], b};
    if (rx_win == FLAG_PATTERN) begin
      if (!rx_open) begin
        rx_open  = 1'b1;
        rx_nbits = 3'd0;
        rx_count = '0;
        rx_crc   = CRC_PRESET;
      end else begin
        rx_open = 1'b0;
        fcs = ~rx_crc;
        if (rx_count < 2 || rx_count < min_len) begin
          model_emit(KIND_SHORT, 8'h00, '0);
        end else if (fcs[7:0] == rx_hold[0] && fcs[15:8] == rx_hold[1]) begin
          model_emit(KIND_GOOD, 8'h00, rx_count - 13'd2);
        end else begin
          model_emit(KIND_CRCFAIL, 8'h00, '0);
        end
      end
    end else if (rx_open) begin
      if (rx_win[6:0] == ABORT_PATTERN) begin
        rx_open = 1'b0;
        model_emit(KIND_ABORT, 8'h00, '0);
      end else if (rx_win[5:0] != STUFF_PATTERN) begin
        rx_shift = {b, rx_shift[7:1]};
        rx_nbits = rx_nbits + 3'd1;
        if (rx_nbits == 3'd0) begin
          if (rx_count >= 2) begin
            rx_crc = x25_step(rx_crc, rx_hold[0]);
            model_emit(KIND_DATA, rx_hold[0], '0);
          end
          rx_hold[0] = rx_hold[1];
          rx_hold[1] = rx_shift;
          rx_count   = rx_count + 13'd1;
          if (rx_count >= max_len) begin
            rx_open = 1'b0;
            model_emit(KIND_OVERSIZE, 8'h00, '0);
          end
        end
      end
    end
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // bias toward bytes that force stuffing or look like flags
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 11))
      0:       return 8'hFF;
      1:       return 8'h7E;
      2:       return 8'h7F;
      3:       return 8'h3E;
      4:       return 8'h00;
      5:       return 8'hF8;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_raw(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) line_q.push_back(v[i]);
  endfunction

  function automatic void push_flag();
    push_raw({24'h0, FLAG_PATTERN}, 8);
    ones_run = 0;
  endfunction

  function automatic void push_data_bit(input logic b);
    line_q.push_back(b);
    if (!b) begin
      ones_run = 0;
    end else if (++ones_run == 5) begin
      line_q.push_back(1'b0);
      ones_run = 0;
    end
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    for (int i = 0; i < 8; i++) push_data_bit(v[i]);
  endfunction

  function automatic void queue_frame(input byte_q_t body, input frame_mode_e mode,
                                      input bit close);
    logic [15:0] crc;
    logic [15:0] fcs;
    crc = CRC_PRESET;
    push_flag();
    foreach (body[i]) begin
      push_byte(body[i]);
      crc = x25_step(crc, body[i]);
    end
    fcs = ~crc;
    if (mode == FR_BAD_FCS) fcs = fcs ^ (16'h1 << $urandom_range(0, 15));
    if (mode != FR_NO_FCS) begin
      push_byte(fcs[7:0]);
      push_byte(fcs[15:8]);
    end
    if (close) push_flag();
  endfunction

  function automatic void queue_random_traffic();
    int unsigned r;
    int unsigned len;
    byte_q_t     body;
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 40);
    repeat (len) body.push_back(pick_byte());
    r = $urandom_range(0, 99);
    if (r < 70) begin
      queue_frame(body, FR_GOOD, 1'b1);
    end else if (r < 80) begin
      queue_frame(body, FR_BAD_FCS, 1'b1);
    end else if (r < 88) begin
      queue_frame(body, FR_NO_FCS, 1'b0);
      repeat ($urandom_range(0, 7)) push_data_bit(1'($urandom_range(0, 1)));
      push_raw(32'hFFFF_FFFF, $urandom_range(7, 10));
    end else if (r < 94) begin
      // no closing flag: the next opening flag ends it
      queue_frame(body, FR_GOOD, 1'b0);
    end else begin
      repeat ($urandom_range(1, 24)) line_q.push_back(1'($urandom_range(0, 1)));
    end
    r = $urandom_range(0, 9);
    if (r >= 8) begin
      push_flag();
    end else if (r >= 5) begin
      push_raw(32'hFFFF_FFFF, $urandom_range(1, 12));
    end
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < 40) $display("ERROR t=%0t: %s", $time, what);
    mismatches++;
  endtask

  // entered and left at a falling edge
  task automatic send_bit(input logic b);
    int unsigned gap;
    if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
    gap = pick_gap(in_calm);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.line_bit <= b;
    do @(posedge clk); while (!in_chan.ready);
    deframe_bit(b);
    @(negedge clk);
  endtask

  task automatic play_line();
    while (line_q.size() != 0) send_bit(line_q.pop_front());
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [LEN_W-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_LEN) min_len = val;
    else max_len = val;
    @(negedge clk);
  endtask

  task automatic check_result();
    hbrd_result_t want;
    results_seen++;
    if (due_results.size() == 0) begin
      note_mismatch($sformatf("unexpected result kind=%0d data=%02h len=%0d",
                              out_chan.kind, out_chan.data_byte, out_chan.body_len));
    end else begin
      want = due_results.pop_front();
      if (out_chan.kind !== want.kind)
        note_mismatch($sformatf("kind %0d, want %0d", out_chan.kind, want.kind));
      if (out_chan.data_byte !== want.data_byte)
        note_mismatch($sformatf("data_byte %02h, want %02h (kind %0d)",
                                out_chan.data_byte, want.data_byte, want.kind));
      if (out_chan.body_len !== want.body_len)
        note_mismatch($sformatf("body_len %0d, want %0d (kind %0d)",
                                out_chan.body_len, want.body_len, want.kind));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) check_result();
  end

  // result side: random stalls, plus one long hold-off once traffic is flowing
  initial begin : result_side
    int unsigned gap_left;
    int unsigned hold_left;
    bit          squeezed;
    gap_left  = 0;
    hold_left = 0;
    squeezed  = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed  = 1'b1;
        hold_left = SQUEEZE_LEN;
      end
      if ($urandom_range(0, 49) == 0) out_calm = !out_calm;
      if (hold_left != 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else if (gap_left != 0) begin
        out_chan.ready <= 1'b0;
        gap_left--;
      end else begin
        out_chan.ready <= 1'b1;
        gap_left = pick_gap(out_calm);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles,
             due_results.size());
    $display("FAIL hdlc_bit_receiver_deframer");
    $finish;
  end

  initial begin : line_side
    stim_row_t        row;
    byte_q_t          body;
    int unsigned      phase_bits;
    logic [LEN_W-1:0] lo;
    logic [LEN_W-1:0] hi;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_MIN_LEN;
    cfg_wdata        = '0;
    in_chan.valid    = 1'b0;
    in_chan.line_bit = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIR_TABLE[i]) begin
      row = DIR_TABLE[i];
      if (row.op == ROW_CFG) begin
        settle();
        write_reg(row.reg_sel, row.pattern[LEN_W-1:0]);
      end else begin
        table_owns_results = row.typed;
        if (row.typed) begin
          repeat (row.n_data) queue_expect(KIND_DATA, row.pattern[7:0], '0);
          if (row.status != KIND_DATA)
            queue_expect(row.status, 8'h00, (row.status == KIND_GOOD) ? row.good_len : '0);
        end
        if (row.op == ROW_BITS) begin
          push_raw(row.pattern, row.count);
        end else begin
          body.delete();
          repeat (row.count)
            body.push_back((row.fmode == FR_RANDOM) ? pick_byte() : row.pattern[7:0]);
          queue_frame(body, row.fmode, 1'b1);
        end
        play_line();
      end
    end
    table_owns_results = 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      lo = 13'($urandom_range(0, 10));
      hi = $urandom_range(0, 1) ? 13'($urandom_range(3, 16)) : 13'($urandom_range(17, 4096));
      write_reg(REG_MIN_LEN, lo);
      write_reg(REG_MAX_LEN, hi);
      phase_bits = 0;
      while (phase_bits < PHASE_BITS) begin
        queue_random_traffic();
        phase_bits += line_q.size();
        play_line();
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("PASS hdlc_bit_receiver_deframer");
    else $display("FAIL hdlc_bit_receiver_deframer");
    $finish;
  end

endmodule

// ===== files.f =====
design/hbrd_pkg.sv
design/hbrd_if.sv
design/hbrd_core.sv
design/hbrd_queue.sv
design/hdlc_bit_receiver_deframer.sv
design/hbrd_checker.sv
tb/tb_hdlc_bit_receiver_deframer.sv
